### rtl/abd_pkg.sv
`timescale 1ns / 1ps
// Package for the anchor box decoder: field widths, register map,
// integer exponent constants and the output saturation function. No dependencies.
package abd_pkg;

    // Field widths
    localparam int IN_W    = 16;
    localparam int OUT_W   = 20;
    localparam int KNOT_W  = 28;
    localparam int LANES   = 2;

    // Pipeline depth from the input register to the output register
    localparam int PIPE_STAGES = 6;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam logic REG_CENTER_VAR = 1'b0;
    localparam logic REG_SIZE_VAR   = 1'b1;

    localparam logic [IN_W-1:0] CENTER_VAR_RESET = 16'd6554;
    localparam logic [IN_W-1:0] SIZE_VAR_RESET   = 16'd13107;

    // e^(n-8) for n = 0..16, unsigned Q.24
    localparam logic [35:0] EXP_INT_Q24 [17] = '{
        36'd5628, 36'd15299, 36'd41587, 36'd113044, 36'd307285, 36'd835288,
        36'd2270549, 36'd6171993, 36'd16777216, 36'd45605201, 36'd123967789,
        36'd336979391, 36'd916004956, 36'd2489959628, 36'd6768412009,
        36'd18398451372, 36'd50012175935
    };

    // Clamp a wide signed value to the signed Q4.16 output range.
    function automatic logic [OUT_W-1:0] sat_q4_16(input logic signed [31:0] v);
        logic [OUT_W-1:0] r;
        if (v > 32'sd524287) begin
            r = 20'h7FFFF;
        end else if (v < -32'sd524288) begin
            r = 20'h80000;
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/anchor_box_decode.sv
`timescale 1ns / 1ps
// Anchor box decoder top level: six-stage pipeline that turns a prior box and its
// regression offsets into saturated corner coordinates. Depends on abd_pkg.
//
// An accepted input word is registered in stage 1 and reaches m_tvalid from stage 6.
// Throughput: one word per cycle while m_tready is high; each stage holds one word and
// moves on when the next stage is free, so only the output handshake can hold the flow.
// Reset (aresetn low, synchronous) empties the pipeline and restores both variances.
// The exponent knot table is a constant built at elaboration and needs no fill.
module anchor_box_decode #(
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // prior_cx, prior_cy, prior_w, prior_h, off_x, off_y, off_w, off_h (16 bits each)
    input  logic [127:0]                      s_tdata,
    // Result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // x_min, y_min, x_max, y_max (20 bits each)
    output logic [79:0]                       m_tdata,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [abd_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int NS     = abd_pkg::PIPE_STAGES;
    localparam int KW     = abd_pkg::KNOT_W;
    localparam int KIDX_W = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int P_W    = 32 + KIDX_W;

    typedef logic [KW-1:0] knot_arr_t [EXP_TABLE_DEPTH + 1];

    // Build the knots of exp(-8 + 16k/depth) in Q.16 from the integer part
    // constant and a truncated Taylor series of the fractional part.
    function automatic knot_arr_t build_exp_knots();
        knot_arr_t   t;
        logic [63:0] num;
        logic [63:0] whole;
        logic [63:0] rem;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] prod;
        for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
            num   = 64'(16 * k);
            whole = num / EXP_TABLE_DEPTH;
            rem   = num % EXP_TABLE_DEPTH;
            x     = (rem << 30) / EXP_TABLE_DEPTH;
            term  = 64'd1 << 30;
            sum   = term;
            term = ((term * x) >> 30) / 64'd1;  sum = sum + term;
            term = ((term * x) >> 30) / 64'd2;  sum = sum + term;
            term = ((term * x) >> 30) / 64'd3;  sum = sum + term;
            term = ((term * x) >> 30) / 64'd4;  sum = sum + term;
            term = ((term * x) >> 30) / 64'd5;  sum = sum + term;
            term = ((term * x) >> 30) / 64'd6;  sum = sum + term;
            term = ((term * x) >> 30) / 64'd7;  sum = sum + term;
            term = ((term * x) >> 30) / 64'd8;  sum = sum + term;
            term = ((term * x) >> 30) / 64'd9;  sum = sum + term;
            term = ((term * x) >> 30) / 64'd10; sum = sum + term;
            term = ((term * x) >> 30) / 64'd11; sum = sum + term;
            term = ((term * x) >> 30) / 64'd12; sum = sum + term;
            term = ((term * x) >> 30) / 64'd13; sum = sum + term;
            term = ((term * x) >> 30) / 64'd14; sum = sum + term;
            term = ((term * x) >> 30) / 64'd15; sum = sum + term;
            term = ((term * x) >> 30) / 64'd16; sum = sum + term;
            sum  = (sum + 64'd32) >> 6;
            prod = 64'(abd_pkg::EXP_INT_Q24[whole[4:0]]) * sum + (64'd1 << 31);
            t[k] = prod[59:32];
        end
        return t;
    endfunction

    localparam knot_arr_t EXP_KNOTS = build_exp_knots();

    // Configuration registers
    logic [15:0] cv_reg;
    logic [15:0] sv_reg;
    logic        cfg_wr;

    // Valid bits and per-stage ready chain
    logic [NS:1]   vld_reg;
    logic [NS+1:1] rdy;

    // Stage 1: offset times variance
    logic        [15:0] c1_reg    [abd_pkg::LANES];
    logic        [15:0] sz1_reg   [abd_pkg::LANES];
    logic signed [31:0] dcv1_reg  [abd_pkg::LANES];
    logic signed [31:0] arg1_reg  [abd_pkg::LANES];
    // Stage 2: center delta and table position
    logic        [15:0]       c2_reg    [abd_pkg::LANES];
    logic        [15:0]       sz2_reg   [abd_pkg::LANES];
    logic signed [48:0]       d2_reg    [abd_pkg::LANES];
    logic        [KIDX_W-1:0] idx2_reg  [abd_pkg::LANES];
    logic        [31:0]       frac2_reg [abd_pkg::LANES];
    // Stage 3: center and knot pair
    logic signed [21:0]   ctr3_reg  [abd_pkg::LANES];
    logic        [15:0]   sz3_reg   [abd_pkg::LANES];
    logic        [KW-1:0] lo3_reg   [abd_pkg::LANES];
    logic        [KW-1:0] diff3_reg [abd_pkg::LANES];
    logic        [31:0]   frac3_reg [abd_pkg::LANES];
    // Stage 4: interpolation product
    logic signed [21:0]   ctr4_reg  [abd_pkg::LANES];
    logic        [15:0]   sz4_reg   [abd_pkg::LANES];
    logic        [KW-1:0] lo4_reg   [abd_pkg::LANES];
    logic        [59:0]   prod4_reg [abd_pkg::LANES];
    // Stage 5: size product
    logic signed [21:0]   ctr5_reg   [abd_pkg::LANES];
    logic        [KW+15:0] sprod5_reg [abd_pkg::LANES];
    // Stage 6: output corners
    logic [abd_pkg::OUT_W-1:0] min6_reg [abd_pkg::LANES];
    logic [abd_pkg::OUT_W-1:0] max6_reg [abd_pkg::LANES];

    // Next values
    logic signed [31:0]        dcv1_next  [abd_pkg::LANES];
    logic signed [31:0]        arg1_next  [abd_pkg::LANES];
    logic signed [48:0]        d2_next    [abd_pkg::LANES];
    logic [KIDX_W-1:0]         idx2_next  [abd_pkg::LANES];
    logic [31:0]               frac2_next [abd_pkg::LANES];
    logic signed [21:0]        ctr3_next  [abd_pkg::LANES];
    logic [KW-1:0]             lo3_next   [abd_pkg::LANES];
    logic [KW-1:0]             diff3_next [abd_pkg::LANES];
    logic [59:0]               prod4_next [abd_pkg::LANES];
    logic [KW+15:0]            sprod5_next[abd_pkg::LANES];
    logic [abd_pkg::OUT_W-1:0] min6_next  [abd_pkg::LANES];
    logic [abd_pkg::OUT_W-1:0] max6_next  [abd_pkg::LANES];

    // Configuration write and read
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_reg <= abd_pkg::CENTER_VAR_RESET;
            sv_reg <= abd_pkg::SIZE_VAR_RESET;
        end else if (cfg_wr) begin
            case (paddr[abd_pkg::CFG_ADDR_W-1])
                abd_pkg::REG_CENTER_VAR: cv_reg <= pwdata[15:0];
                abd_pkg::REG_SIZE_VAR:   sv_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[abd_pkg::CFG_ADDR_W-1])
            abd_pkg::REG_CENTER_VAR: prdata = {16'd0, cv_reg};
            abd_pkg::REG_SIZE_VAR:   prdata = {16'd0, sv_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    // A stage takes a new word when it is empty or its word moves on.
    always_comb begin
        rdy[NS+1] = m_tready;
        for (int k = NS; k >= 1; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign s_tready = rdy[1];
    assign m_tvalid = vld_reg[NS];
    assign m_tdata  = {max6_reg[1], max6_reg[0], min6_reg[1], min6_reg[0]};

    // Datapath arithmetic for both axes
    always_comb begin
        logic signed [32:0]  m1c;
        logic signed [32:0]  m1s;
        logic [31:0]         u2;
        logic [P_W-1:0]      p2;
        logic signed [48:0]  dr3;
        logic signed [20:0]  dsh3;
        logic [KW-1:0]       hi3;
        logic [60:0]         rsum5;
        logic [KW:0]         e5;
        logic [KW+16:0]      ssum6;
        logic [KW:0]         s6;
        logic signed [31:0]  mn6;
        logic signed [31:0]  mx6;
        for (int l = 0; l < abd_pkg::LANES; l++) begin
            // Stage 1: offsets scaled by the variances
            m1c = $signed(s_tdata[64 + l*16 +: 16]) * $signed({1'b0, cv_reg});
            m1s = $signed(s_tdata[96 + l*16 +: 16]) * $signed({1'b0, sv_reg});
            dcv1_next[l] = m1c[31:0];
            arg1_next[l] = m1s[31:0];

            // Stage 2: center delta in Q.44, knot index and fraction
            d2_next[l] = dcv1_reg[l] * $signed({1'b0, sz1_reg[l]});
            u2 = {~arg1_reg[l][31], arg1_reg[l][30:0]};
            p2 = {{KIDX_W{1'b0}}, u2} * P_W'(EXP_TABLE_DEPTH);
            idx2_next[l]  = p2[P_W-1:32];
            frac2_next[l] = p2[31:0];

            // Stage 3: round the delta to Q.16, fetch the neighboring knots
            dr3  = d2_reg[l] + 49'sd134217728;
            dsh3 = dr3[48:28];
            ctr3_next[l] = $signed({6'd0, c2_reg[l]}) + $signed({dsh3[20], dsh3});
            lo3_next[l]  = EXP_KNOTS[idx2_reg[l]];
            hi3          = EXP_KNOTS[KIDX_W'(idx2_reg[l] + 1'b1)];
            diff3_next[l] = (hi3 >= lo3_next[l]) ? (hi3 - lo3_next[l]) : '0;

            // Stage 4: interpolation product
            prod4_next[l] = diff3_reg[l] * frac3_reg[l];

            // Stage 5: finish the exponent and scale the prior size
            rsum5 = {1'b0, prod4_reg[l]} + 61'h0_8000_0000;
            e5    = {1'b0, lo4_reg[l]} + rsum5[60:32];
            sprod5_next[l] = sz4_reg[l] * e5[KW-1:0];

            // Stage 6: round the size and form the saturated corners
            ssum6 = {1'b0, sprod5_reg[l]} + (KW+17)'(32768);
            s6    = ssum6[KW+16:16];
            mn6   = $signed({{10{ctr5_reg[l][21]}}, ctr5_reg[l]})
                    - $signed({4'd0, s6[KW:1]});
            mx6   = mn6 + $signed({3'd0, s6});
            min6_next[l] = abd_pkg::sat_q4_16(mn6);
            max6_next[l] = abd_pkg::sat_q4_16(mx6);
        end
    end

    // Valid bits travel with the words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[1]) begin
                vld_reg[1] <= s_tvalid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Payload registers, loaded when their stage advances
    always_ff @(posedge aclk) begin
        for (int l = 0; l < abd_pkg::LANES; l++) begin
            if (rdy[1]) begin
                c1_reg[l]   <= s_tdata[l*16 +: 16];
                sz1_reg[l]  <= s_tdata[32 + l*16 +: 16];
                dcv1_reg[l] <= dcv1_next[l];
                arg1_reg[l] <= arg1_next[l];
            end
            if (rdy[2]) begin
                c2_reg[l]    <= c1_reg[l];
                sz2_reg[l]   <= sz1_reg[l];
                d2_reg[l]    <= d2_next[l];
                idx2_reg[l]  <= idx2_next[l];
                frac2_reg[l] <= frac2_next[l];
            end
            if (rdy[3]) begin
                ctr3_reg[l]  <= ctr3_next[l];
                sz3_reg[l]   <= sz2_reg[l];
                lo3_reg[l]   <= lo3_next[l];
                diff3_reg[l] <= diff3_next[l];
                frac3_reg[l] <= frac2_reg[l];
            end
            if (rdy[4]) begin
                ctr4_reg[l]  <= ctr3_reg[l];
                sz4_reg[l]   <= sz3_reg[l];
                lo4_reg[l]   <= lo3_reg[l];
                prod4_reg[l] <= prod4_next[l];
            end
            if (rdy[5]) begin
                ctr5_reg[l]   <= ctr4_reg[l];
                sprod5_reg[l] <= sprod5_next[l];
            end
            if (rdy[6]) begin
                min6_reg[l] <= min6_next[l];
                max6_reg[l] <= max6_next[l];
            end
        end
    end

    // An empty output register never holds back the input.
    a_ready_when_out_empty: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !vld_reg[NS] |-> s_tready
    ) else $error("input stalled while the output register is empty");

    // A stalled middle stage keeps its word.
    a_stage3_holds: assert property (
        @(posedge aclk) disable iff (!aresetn)
        vld_reg[3] && !rdy[3] |=> vld_reg[3] && $stable(lo3_reg[0]) && $stable(ctr3_reg[1])
    ) else $error("stage 3 word lost or changed during a stall");

    // A center variance write lands in its register.
    a_cv_write: assert property (
        @(posedge aclk) disable iff (!aresetn)
        cfg_wr && paddr[abd_pkg::CFG_ADDR_W-1] == abd_pkg::REG_CENTER_VAR
        |=> cv_reg == $past(pwdata[15:0])
    ) else $error("center variance write not applied");

    // Reset leaves the pipeline empty.
    a_reset_empty: assert property (
        @(posedge aclk)
        !aresetn |=> vld_reg == '0
    ) else $error("pipeline not empty after reset");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the anchor box decoder: streams prior boxes with offsets,
// predicts the decoded corners in fixed point and compares every result word.
// Depends on abd_pkg and the anchor_box_decode RTL.
module testbench;

    localparam int  KNOTS       = 256;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  HOLD_CYCLES = 400;
    localparam real HALF_PERIOD = 6.0;
    localparam int  ADDR_W      = abd_pkg::CFG_ADDR_W;
    localparam int  OW          = abd_pkg::OUT_W;

    // e^(n-8) for n = 0..16 in unsigned Q.24, the integer part of every knot
    localparam longint EXP_WHOLE_Q24 [17] = '{
        64'd5628, 64'd15299, 64'd41587, 64'd113044, 64'd307285, 64'd835288,
        64'd2270549, 64'd6171993, 64'd16777216, 64'd45605201, 64'd123967789,
        64'd336979391, 64'd916004956, 64'd2489959628, 64'd6768412009,
        64'd18398451372, 64'd50012175935
    };

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // prior_cx, prior_cy, prior_w, prior_h, off_x, off_y, off_w, off_h (16 bits each)
    logic [127:0]          s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // x_min, y_min, x_max, y_max (20 bits each)
    logic [79:0]           m_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // Testbench copies of the variance registers and the exp knot table
    logic [abd_pkg::IN_W-1:0] center_var_q = abd_pkg::CENTER_VAR_RESET;
    logic [abd_pkg::IN_W-1:0] size_var_q   = abd_pkg::SIZE_VAR_RESET;
    longint          exp_knot [0:KNOTS];

    logic [127:0] prior_queue [$];
    logic [79:0]  corner_queue [$];
    int           mismatches   = 0;
    int           results_seen = 0;
    int           cycle_count  = 0;
    int           send_gap     = 0;
    int           stall_left   = 0;
    int           hold_left    = 0;
    bit           hold_done    = 1'b0;
    bit           quiet        = 1'b0;

    anchor_box_decode #(
        .EXP_TABLE_DEPTH(KNOTS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #(HALF_PERIOD) aclk = ~aclk;
    end

    // Saturate to the signed Q4.16 output range.
    function automatic logic [OW-1:0] clamp_q4_16(input longint v);
        longint c;
        c = v;
        if (c > 524287) c = 524287;
        if (c < -524288) c = -524288;
        return c[OW-1:0];
    endfunction

    // Decode one axis: shifted center, exp-scaled size, then the two corners.
    function automatic void decode_axis(input logic [15:0] ctr_in, input logic [15:0] size_in,
                                        input logic signed [15:0] off_c,
                                        input logic signed [15:0] off_s,
                                        output logic [OW-1:0] lo, output logic [OW-1:0] hi);
        longint d, ctr, arg, u, p, idx, frac, k_lo, k_hi, e, s, mn;
        d   = longint'(off_c) * longint'(center_var_q) * longint'(size_in);
        ctr = longint'(ctr_in) + ((d + (longint'(1) << 27)) >>> 28);
        arg = longint'(off_s) * longint'(size_var_q);
        if (arg < -(longint'(8) << 28)) arg = -(longint'(8) << 28);
        if (arg > (longint'(8) << 28) - 1) arg = (longint'(8) << 28) - 1;
        u    = arg + (longint'(8) << 28);
        p    = u * KNOTS;
        idx  = p >> 32;
        if (idx >= KNOTS) idx = KNOTS - 1;
        frac = p & 64'hFFFF_FFFF;
        k_lo = exp_knot[idx];
        k_hi = exp_knot[idx + 1];
        if (k_hi < k_lo) k_hi = k_lo;
        e  = k_lo + (((k_hi - k_lo) * frac + (longint'(1) << 31)) >> 32);
        s  = (longint'(size_in) * e + 32768) >> 16;
        mn = ctr - (s >> 1);
        lo = clamp_q4_16(mn);
        hi = clamp_q4_16(mn + s);
    endfunction

    // Expected corner word for one prior word under the current variances.
    function automatic logic [79:0] decode_corners(input logic [127:0] w);
        logic [OW-1:0] x0, y0, x1, y1;
        decode_axis(w[15:0], w[47:32], w[79:64], w[111:96], x0, x1);
        decode_axis(w[31:16], w[63:48], w[95:80], w[127:112], y0, y1);
        return {y1, x1, y0, x0};
    endfunction

    function automatic logic [127:0] pack_prior(input logic [15:0] cx, input logic [15:0] cy,
                                                input logic [15:0] w, input logic [15:0] h,
                                                input logic [15:0] ox, input logic [15:0] oy,
                                                input logic [15:0] ow, input logic [15:0] oh);
        return {oh, ow, oy, ox, h, w, cy, cx};
    endfunction

    function automatic logic [15:0] edge_value();
        logic [15:0] v;
        case ($urandom_range(0, 5))
            0: v = 16'h0000;
            1: v = 16'hFFFF;
            2: v = 16'h7FFF;
            3: v = 16'h8000;
            4: v = 16'h0001;
            default: v = 16'($urandom());
        endcase
        return v;
    endfunction

    // Mostly realistic boxes with offsets within about +-3.0, plus raw and edge values.
    function automatic logic [127:0] random_prior();
        logic [15:0] f [8];
        int          pick;
        pick = $urandom_range(0, 19);
        for (int i = 0; i < 8; i++) begin
            if (pick < 14) begin
                f[i] = (i < 4) ? 16'($urandom()) : 16'($urandom_range(0, 24576) - 12288);
            end else if (pick < 17) begin
                f[i] = 16'($urandom());
            end else begin
                f[i] = edge_value();
            end
        end
        return pack_prior(f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7]);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // One register write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic sel, input logic [15:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({sel, 2'b00});
        pwdata  <= {16'($urandom()), value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (sel == abd_pkg::REG_CENTER_VAR) begin
            center_var_q = value;
        end else begin
            size_var_q = value;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_variances(input logic [15:0] cv, input logic [15:0] sv);
        write_reg(abd_pkg::REG_CENTER_VAR, cv);
        write_reg(abd_pkg::REG_SIZE_VAR, sv);
    endtask

    // Wait until every queued word is accepted and every result has come back.
    task automatic drain();
        while (prior_queue.size() != 0 || s_tvalid || corner_queue.size() != 0) begin
            @(negedge aclk);
        end
        repeat (abd_pkg::PIPE_STAGES + 2) @(posedge aclk);
    endtask

    task automatic run_random(input int count);
        repeat (count) prior_queue.push_back(random_prior());
        drain();
    endtask

    // Stimulus sequence
    initial begin
        logic [15:0] cv, sv;
        for (int k = 0; k <= KNOTS; k++) begin
            longint num, whole, rem, x, term, sum;
            num   = 16 * k;
            whole = num / KNOTS;
            rem   = num % KNOTS;
            x     = (rem << 30) / KNOTS;
            term  = longint'(1) << 30;
            sum   = term;
            for (int n = 1; n <= 16; n++) begin
                term = ((term * x) >> 30) / n;
                sum  = sum + term;
            end
            sum = (sum + 32) >> 6;
            exp_knot[k] = (EXP_WHOLE_Q24[whole] * sum + (longint'(1) << 31)) >> 32;
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Default variances: plain boxes, extreme fields and zero sizes
        prior_queue.push_back(pack_prior(0, 0, 0, 0, 0, 0, 0, 0));
        prior_queue.push_back(pack_prior(16'h8000, 16'h8000, 16'h4000, 16'h4000, 0, 0, 0, 0));
        prior_queue.push_back(pack_prior(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0));
        prior_queue.push_back(pack_prior(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                         16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        prior_queue.push_back(pack_prior(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                         16'h8000, 16'h8000, 16'h8000, 16'h8000));
        prior_queue.push_back(pack_prior(16'h1234, 16'hABCD, 0, 0,
                                         16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
        prior_queue.push_back(pack_prior(0, 0, 16'h2000, 16'h2000,
                                         16'hC000, 16'hC000, 16'h1000, 16'hF000));
        prior_queue.push_back(pack_prior(16'hFFFF, 0, 16'hFFFF, 16'hFFFF,
                                         16'h4000, 16'hC000, 16'h7FFF, 16'h7FFF));
        prior_queue.push_back(pack_prior(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555,
                                         16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
        prior_queue.push_back(pack_prior(16'h0001, 16'h0001, 16'h0001, 16'h0001,
                                         16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF));
        drain();

        // Largest variances: saturation on both sides and exp near its bounds
        set_variances(16'hFFFF, 16'hFFFF);
        prior_queue.push_back(pack_prior(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                         16'h7FFF, 16'h7FFF, 0, 0));
        prior_queue.push_back(pack_prior(0, 0, 16'hFFFF, 16'hFFFF,
                                         16'h8000, 16'h8000, 0, 0));
        prior_queue.push_back(pack_prior(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF,
                                         0, 0, 16'h7FFF, 16'h7FFF));
        prior_queue.push_back(pack_prior(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF,
                                         0, 0, 16'h8000, 16'h8000));
        prior_queue.push_back(pack_prior(16'h8000, 16'h8000, 0, 0,
                                         16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
        prior_queue.push_back(pack_prior(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                         16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        prior_queue.push_back(pack_prior(16'h0100, 16'hFF00, 16'h0800, 16'h0800,
                                         16'h9000, 16'h7000, 16'h3000, 16'hD000));
        run_random(200);

        // Zero variances: centers stay put and sizes are scaled by one
        set_variances(16'h0000, 16'h0000);
        run_random(150);

        // Assorted random settings
        repeat (4) begin
            cv = 16'($urandom());
            sv = ($urandom_range(0, 1) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 20000));
            set_variances(cv, sv);
            run_random(180);
        end

        // Back to the reset values, with no idling on either side
        set_variances(abd_pkg::CENTER_VAR_RESET, abd_pkg::SIZE_VAR_RESET);
        quiet = 1'b1;
        run_random(150);

        repeat (abd_pkg::PIPE_STAGES * 4) @(posedge aclk);
        if (mismatches == 0 && corner_queue.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // Input driver: predicts each accepted word and offers the next one.
    always @(posedge aclk) begin : prior_driver
        logic offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            offer = s_tvalid;
            if (s_tvalid && s_tready) begin
                corner_queue.push_back(decode_corners(s_tdata));
                offer = 1'b0;
            end
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (prior_queue.size() != 0) begin
                    s_tdata <= prior_queue.pop_front();
                    offer = 1'b1;
                    if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 12);
                end
            end
            s_tvalid <= offer;
        end
    end

    // Result receiver: random stall bursts and one long hold-off to back up the pipeline.
    always @(posedge aclk) begin : corner_receiver
        logic ready;
        if (!quiet && !hold_done && results_seen >= 150) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            ready = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            ready = 1'b0;
        end else begin
            ready = 1'b1;
            if (!quiet && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 12);
        end
        m_tready <= ready;
    end

    // Result monitor: compare each accepted word against the oldest prediction.
    always @(posedge aclk) begin : corner_monitor
        logic [79:0] want;
        string       names [4];
        names = '{"x_min", "y_min", "x_max", "y_max"};
        if (aresetn && m_tvalid && m_tready) begin
            if (corner_queue.size() == 0) begin
                report_mismatch($sformatf("unexpected result word %h", m_tdata));
            end else begin
                want = corner_queue.pop_front();
                for (int f = 0; f < 4; f++) begin
                    if (m_tdata[20*f +: 20] !== want[20*f +: 20]) begin
                        report_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                        results_seen, names[f], m_tdata[20*f +: 20],
                                        want[20*f +: 20]));
                    end
                end
            end
            results_seen++;
        end
    end

    // Watchdog
    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

endmodule
